>>> hdl/interval_set_point_merge_top_macros.svh
// assertion macros for the interval set point merge block
`ifndef INTERVAL_SET_POINT_MERGE_TOP_MACROS_SVH
`define INTERVAL_SET_POINT_MERGE_TOP_MACROS_SVH

// same-cycle implication, checked at every rising edge outside reset
`define ISPM_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked at every rising edge outside reset
`define ISPM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ispm_pkg.sv
// shared types and constants for the interval set point merge block
package ispm_pkg;

	localparam int MAX_RANGES_DEF = 32;
	localparam int POINT_BITS_DEF = 16;
	localparam int POINT_W        = 16;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_FIN,
		ST_DONE
	} ispm_state_t;

endpackage

>>> hdl/interval_set_point_merge_top.sv
// Sorted set of disjoint closed point ranges with point add and point query.
// Input channel: in_valid / in_stall with kind and point. A request is taken
// when in_valid is high and in_stall is low; in_stall is high while a request
// is being worked on, so one request is handled at a time.
// Output channel: out_valid / out_stall with added, covered and overflow, one
// result per request, held in an output register until taken.
// Ranges live in one memory of {first, last} pairs with a registered read.
// A request enters, then the scan reads entries (up to the first range
// starting above the point), then a decide step; for an insert or a bridge
// the entries are moved one at a time and the copy is finished, an insert
// then writes its new range, and at last the output register is loaded. The
// scan and the entry shift both go over the single memory read port.
// A finished result moves to the output register as soon as it is empty or
// being taken; the next request is accepted while that result waits. If the
// receiver stalls with a result already waiting, the block holds its result.
// Reset empties the set (count to zero); memory contents need no clearing.
module interval_set_point_merge_top #(
	parameter int MAX_RANGES = ispm_pkg::MAX_RANGES_DEF,
	parameter int POINT_BITS = ispm_pkg::POINT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        kind,
	input  logic [ispm_pkg::POINT_W-1:0] point,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        added,
	output logic                        covered,
	output logic                        overflow
);
	import ispm_pkg::*;

	`include "interval_set_point_merge_top_macros.svh"

	localparam int PW = POINT_BITS;
	localparam int CW = $clog2(MAX_RANGES + 1);
	localparam int AW = $clog2(MAX_RANGES);

	ispm_state_t state_q, state_d;

	logic [2*PW-1:0] mem [MAX_RANGES];
	logic [2*PW-1:0] rd_q;
	logic            rd_en;
	logic [AW-1:0]   rd_addr;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [2*PW-1:0] wr_data;

	logic [31:0]   pt_ext;
	logic [PW-1:0] p_in;

	logic          kind_q, kind_d;
	logic [PW-1:0] p_q, p_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] i_q, i_d;
	logic [PW-1:0] pf_q, pf_d, pl_q, pl_d;
	logic [PW-1:0] af_q, af_d, al_q, al_d;
	logic          hb_q, hb_d, ha_q, ha_d;
	logic [CW-1:0] s_q, s_d;
	logic [CW-1:0] rem_q, rem_d;
	logic          up_q, up_d;
	logic          cp_s1, cp_d;
	logic [AW-1:0] d_s1, d_d;
	logic          ra_q, ra_d, rc_q, rc_d, ro_q, ro_d;
	logic          ov_q, ov_d, oa_q, oa_d, oc_q, oc_d, oo_q, oo_d;

	logic [PW-1:0] rd_first, rd_last;
	logic [CW-1:0] i_nx, i_m1, s_inc, s_dec;
	logic          adj_lo, adj_hi, in_range;

	assign pt_ext   = 32'(point);
	assign p_in     = pt_ext[PW-1:0];
	assign rd_first = rd_q[2*PW-1:PW];
	assign rd_last  = rd_q[PW-1:0];
	assign i_nx     = i_q + CW'(1);
	assign i_m1     = i_q - CW'(1);
	assign s_inc    = s_q + CW'(1);
	assign s_dec    = s_q - CW'(1);
	assign adj_lo   = ({1'b0, pl_q} + (PW+1)'(1)) == {1'b0, p_q};
	assign adj_hi   = ({1'b0, p_q} + (PW+1)'(1)) == {1'b0, af_q};
	assign in_range = hb_q && (pl_q >= p_q);

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = ov_q;
	assign added     = oa_q;
	assign covered   = oc_q;
	assign overflow  = oo_q;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d  = kind_q;
		p_d     = p_q;
		cnt_d   = cnt_q;
		i_d     = i_q;
		pf_d    = pf_q;
		pl_d    = pl_q;
		af_d    = af_q;
		al_d    = al_q;
		hb_d    = hb_q;
		ha_d    = ha_q;
		s_d     = s_q;
		rem_d   = rem_q;
		up_d    = up_q;
		cp_d    = cp_s1;
		d_d     = d_s1;
		ra_d    = ra_q;
		rc_d    = rc_q;
		ro_d    = ro_q;
		ov_d    = ov_q;
		oa_d    = oa_q;
		oc_d    = oc_q;
		oo_d    = oo_q;
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = '0;

		if (ov_q && !out_stall) begin
			ov_d = 1'b0;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					kind_d = kind;
					p_d    = p_in;
					i_d    = '0;
					hb_d   = 1'b0;
					ha_d   = 1'b0;
					if (cnt_q == '0) begin
						state_d = ST_DECIDE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = '0;
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (rd_first <= p_q) begin
					pf_d = rd_first;
					pl_d = rd_last;
					hb_d = 1'b1;
					i_d  = i_nx;
					if (i_nx < cnt_q) begin
						rd_en   = 1'b1;
						rd_addr = i_nx[AW-1:0];
					end else begin
						state_d = ST_DECIDE;
					end
				end else begin
					af_d    = rd_first;
					al_d    = rd_last;
					ha_d    = 1'b1;
					state_d = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				ra_d    = 1'b0;
				rc_d    = 1'b0;
				ro_d    = 1'b0;
				state_d = ST_DONE;
				priority if (kind_q == KIND_QUERY) begin
					rc_d = in_range;
				end else if (in_range) begin
					rc_d = 1'b1;
				end else if (hb_q && ha_q && adj_lo && adj_hi) begin
					wr_en   = 1'b1;
					wr_addr = i_m1[AW-1:0];
					wr_data = {pf_q, al_q};
					ra_d    = 1'b1;
					cnt_d   = cnt_q - CW'(1);
					up_d    = 1'b0;
					s_d     = i_nx;
					rem_d   = cnt_q - i_nx;
					cp_d    = 1'b0;
					state_d = ST_SHIFT;
				end else if (hb_q && adj_lo) begin
					wr_en   = 1'b1;
					wr_addr = i_m1[AW-1:0];
					wr_data = {pf_q, p_q};
					ra_d    = 1'b1;
				end else if (ha_q && adj_hi) begin
					wr_en   = 1'b1;
					wr_addr = i_q[AW-1:0];
					wr_data = {p_q, al_q};
					ra_d    = 1'b1;
				end else if (cnt_q == CW'(MAX_RANGES)) begin
					ro_d = 1'b1;
				end else begin
					ra_d    = 1'b1;
					cnt_d   = cnt_q + CW'(1);
					up_d    = 1'b1;
					s_d     = cnt_q - CW'(1);
					rem_d   = cnt_q - i_q;
					cp_d    = 1'b0;
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (cp_s1) begin
					wr_en   = 1'b1;
					wr_addr = d_s1;
					wr_data = rd_q;
				end
				if (rem_q != '0) begin
					rd_en   = 1'b1;
					rd_addr = s_q[AW-1:0];
					cp_d    = 1'b1;
					d_d     = up_q ? s_inc[AW-1:0] : s_dec[AW-1:0];
					s_d     = up_q ? s_dec : s_inc;
					rem_d   = rem_q - CW'(1);
				end else begin
					cp_d    = 1'b0;
					state_d = up_q ? ST_FIN : ST_DONE;
				end
			end
			ST_FIN: begin
				wr_en   = 1'b1;
				wr_addr = i_q[AW-1:0];
				wr_data = {p_q, p_q};
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!ov_q || !out_stall) begin
					ov_d    = 1'b1;
					oa_d    = ra_q;
					oc_d    = rc_q;
					oo_d    = ro_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cp_s1 <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			cp_s1 <= cp_d;
			ov_q  <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		p_q    <= p_d;
		i_q    <= i_d;
		pf_q   <= pf_d;
		pl_q   <= pl_d;
		af_q   <= af_d;
		al_q   <= al_d;
		hb_q   <= hb_d;
		ha_q   <= ha_d;
		s_q    <= s_d;
		rem_q  <= rem_d;
		up_q   <= up_d;
		d_s1   <= d_d;
		ra_q   <= ra_d;
		rc_q   <= rc_d;
		ro_q   <= ro_d;
		oa_q   <= oa_d;
		oc_q   <= oc_d;
		oo_q   <= oo_d;
	end

	`ISPM_ASSERT_SAME(a_cnt_bound, 1'b1, cnt_q <= CW'(MAX_RANGES), "range count above capacity")
	`ISPM_ASSERT_NEXT(a_accept_start, in_valid && !in_stall, state_q == ST_SCAN || state_q == ST_DECIDE, "request did not start a scan")
	`ISPM_ASSERT_SAME(a_ovf_full, state_q == ST_DONE && ro_q, cnt_q == CW'(MAX_RANGES), "overflow with free entries")
	`ISPM_ASSERT_SAME(a_flags_excl, out_valid, $onehot0({added, covered, overflow}), "result flags not exclusive")
	`ISPM_ASSERT_SAME(a_copy_in_shift, cp_s1, state_q == ST_SHIFT, "entry copy pending outside shift")

endmodule
